// ===== sv/psc_pkg.sv =====
// ----------------------------------------------------------------------------
// psc_pkg: shared definitions for the PID steering controller
// Field widths, fixed-point format, register indexes and reset values.
// ----------------------------------------------------------------------------
package psc_pkg;

  // Fixed-point format of the gains and the accumulated error width.
  localparam int GAIN_FRAC = 8;
  localparam int SUM_W     = 24;

  // Field widths.
  localparam int ERR_W     = 11;
  localparam int GAIN_W    = 16;
  localparam int ILIM_W    = 23;
  localparam int SLIM_W    = 7;
  localparam int DBAND_W   = 10;
  localparam int STEER_W   = 8;
  localparam int P_W       = 27;
  localparam int I_W       = 40;
  localparam int D_W       = 28;
  localparam int DIFF_W    = ERR_W + 1;
  localparam int TOT_W     = I_W + 1;
  localparam int U_W       = TOT_W - GAIN_FRAC;

  // Stream word widths, padded to whole bytes.
  localparam int IN_DATA_W  = 16;
  localparam int OUT_FLD_W  = STEER_W + P_W + I_W + D_W;
  localparam int OUT_DATA_W = ((OUT_FLD_W + 7) / 8) * 8;

  // Configuration port.
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = ILIM_W;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_P_GAIN    = 3'd0,
    CFG_I_GAIN    = 3'd1,
    CFG_D_GAIN    = 3'd2,
    CFG_WIND_LIM  = 3'd3,
    CFG_STEER_MAX = 3'd4,
    CFG_DEADZONE  = 3'd5
  } cfg_idx_t;

  // Request kinds carried on in_tuser.
  localparam logic REQ_UPDATE = 1'b0;
  localparam logic REQ_RESET  = 1'b1;

  // Register reset values.
  localparam logic signed [GAIN_W-1:0] P_GAIN_RST    = 16'sd154;
  localparam logic signed [GAIN_W-1:0] I_GAIN_RST    = 16'sd0;
  localparam logic signed [GAIN_W-1:0] D_GAIN_RST    = 16'sd102;
  localparam logic [ILIM_W-1:0]        WIND_LIM_RST  = 23'd8388607;
  localparam logic [SLIM_W-1:0]        STEER_MAX_RST = 7'd8;
  localparam logic [DBAND_W-1:0]       DEADZONE_RST  = 10'd0;

  // Error range ends.
  localparam logic signed [ERR_W-1:0] ERR_MAX = 11'sd1023;
  localparam logic signed [ERR_W-1:0] ERR_MIN = -11'sd1024;

  // Integrator full scale and the rounding offset of the fixed-point sum.
  localparam logic signed [SUM_W:0]   SUM_MAX  = (SUM_W+1)'((64'sd1 <<< (SUM_W-1)) - 1);
  localparam logic signed [TOT_W-1:0] RND_HALF = TOT_W'(64'sd1 <<< (GAIN_FRAC-1));

endpackage

// ===== sv/pid_steering_controller.sv =====
// ----------------------------------------------------------------------------
// pid_steering_controller: discrete PID steering controller with anti wind-up
// Registered single-pass datapath between an input register and a result
// register; the integrator and error history update once per update word.
// ----------------------------------------------------------------------------
// The block takes one word per clock cycle while the result stream is not
// stalled and returns one result word for each, in order, after it has passed
// the input register and the result register. The accumulate-and-clamp of the
// error sum and the three gain multipliers, which sit in parallel, lie between
// the input register and the result register. A stalled result holds in the
// output register while the input register still takes one more word.
// A reset word (in_tuser = 1) clears the integrator and the previous error and
// answers all zeros. Configuration writes are always taken and must be made
// while the block is idle; writes to unknown indexes are ignored.
module pid_steering_controller
  import psc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  // Input stream
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // [10:0] process_error, rest zero
  input  logic                  in_tuser,   // [0] req_type
  // Result stream
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // [7:0] steering, [34:8] p_term, [74:35] i_term, [102:75] d_term, [103] zero
  output logic [OUT_DATA_W-1:0] out_tdata,
  // Configuration write port
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  // Configuration registers.
  logic signed [GAIN_W-1:0] p_gain_r, i_gain_r, d_gain_r;
  logic [ILIM_W-1:0]        wind_lim_r;
  logic [SLIM_W-1:0]        steer_max_r;
  logic [DBAND_W-1:0]       deadzone_r;

  // Input register.
  logic                    s1_valid_r;
  logic                    s1_req_r;
  logic signed [ERR_W-1:0] s1_err_r;

  // Controller state.
  logic signed [SUM_W-1:0] error_sum_r, error_sum_nxt;
  logic signed [ERR_W-1:0] prev_err_r, prev_err_nxt;

  // Result register.
  logic                  out_valid_r;
  logic [OUT_FLD_W-1:0]  out_fld_r, out_fld_nxt;

  logic advance;

  // Datapath signals.
  logic signed [ERR_W-1:0]   e_neg, e_abs, e_dz;
  logic [DBAND_W-1:0]        mag;
  logic signed [SUM_W:0]     sum_ext, lim, lim_raw, sum_clamp;
  logic signed [DIFF_W-1:0]  diff;
  logic signed [P_W-1:0]     p_term;
  logic signed [I_W-1:0]     i_term;
  logic signed [D_W-1:0]     d_term;
  logic signed [TOT_W-1:0]   total;
  logic signed [U_W-1:0]     u, sl;
  logic signed [U_W-1:0]     u_clamp;
  logic signed [STEER_W-1:0] steering;

  // Handshake: the output register frees when empty or taken.
  assign advance    = !out_valid_r || out_tready;
  assign in_tready  = !s1_valid_r || advance;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_DATA_W'(out_fld_r);
  assign cfg_ready  = 1'b1;

  // Error conditioning: negate with saturation, then the deadband.
  always_comb begin
    e_neg = (s1_err_r == ERR_MIN) ? ERR_MAX : -s1_err_r;
    e_abs = e_neg[ERR_W-1] ? -e_neg : e_neg;
    mag   = e_abs[DBAND_W-1:0];
    e_dz  = (mag <= deadzone_r) ? '0 : e_neg;
  end

  // Integrator with a symmetric clamp at the smaller of the limit and full scale.
  always_comb begin
    sum_ext = (SUM_W+1)'(error_sum_r) + (SUM_W+1)'(e_dz);
    lim_raw = (SUM_W+1)'({1'b0, wind_lim_r});
    lim     = (lim_raw > SUM_MAX) ? SUM_MAX : lim_raw;
    if (sum_ext > lim) begin
      sum_clamp = lim;
    end else if (sum_ext < -lim) begin
      sum_clamp = -lim;
    end else begin
      sum_clamp = sum_ext;
    end
  end

  // Gain products, sum, round half up and clamp to the steering limit.
  always_comb begin
    diff    = DIFF_W'(e_dz) - DIFF_W'(prev_err_r);
    p_term  = P_W'(p_gain_r) * P_W'(e_dz);
    i_term  = I_W'(i_gain_r) * I_W'($signed(sum_clamp[SUM_W-1:0]));
    d_term  = D_W'(d_gain_r) * D_W'(diff);
    total   = TOT_W'(p_term) + TOT_W'(i_term) + TOT_W'(d_term) + RND_HALF;
    u       = total[TOT_W-1:GAIN_FRAC];
    sl      = U_W'({1'b0, steer_max_r});
    if (u > sl) begin
      u_clamp = sl;
    end else if (u < -sl) begin
      u_clamp = -sl;
    end else begin
      u_clamp = u;
    end
    steering = u_clamp[STEER_W-1:0];
  end

  // Next state and result word for the word in the input register.
  always_comb begin
    error_sum_nxt = error_sum_r;
    prev_err_nxt  = prev_err_r;
    if (s1_req_r == REQ_RESET) begin
      out_fld_nxt = '0;
    end else begin
      out_fld_nxt = {d_term, i_term, p_term, steering};
    end
    if (s1_valid_r && advance) begin
      if (s1_req_r == REQ_RESET) begin
        error_sum_nxt = '0;
        prev_err_nxt  = '0;
      end else begin
        error_sum_nxt = sum_clamp[SUM_W-1:0];
        prev_err_nxt  = e_dz;
      end
    end
  end

  // Control, configuration and state registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      error_sum_r <= '0;
      prev_err_r  <= '0;
      p_gain_r    <= P_GAIN_RST;
      i_gain_r    <= I_GAIN_RST;
      d_gain_r    <= D_GAIN_RST;
      wind_lim_r  <= WIND_LIM_RST;
      steer_max_r <= STEER_MAX_RST;
      deadzone_r  <= DEADZONE_RST;
    end else begin
      if (in_tready) begin
        s1_valid_r <= in_tvalid;
      end
      if (advance) begin
        out_valid_r <= s1_valid_r;
      end
      error_sum_r <= error_sum_nxt;
      prev_err_r  <= prev_err_nxt;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_P_GAIN:    p_gain_r    <= cfg_data[GAIN_W-1:0];
          CFG_I_GAIN:    i_gain_r    <= cfg_data[GAIN_W-1:0];
          CFG_D_GAIN:    d_gain_r    <= cfg_data[GAIN_W-1:0];
          CFG_WIND_LIM:  wind_lim_r  <= cfg_data[ILIM_W-1:0];
          CFG_STEER_MAX: steer_max_r <= cfg_data[SLIM_W-1:0];
          CFG_DEADZONE:  deadzone_r  <= cfg_data[DBAND_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_req_r <= in_tuser;
      s1_err_r <= in_tdata[ERR_W-1:0];
    end
    if (advance && s1_valid_r) begin
      out_fld_r <= out_fld_nxt;
    end
  end

endmodule

// ===== sv/psc_checker.sv =====
// ----------------------------------------------------------------------------
// psc_checker: port-level checks for the PID steering controller
// Watches the top-level ports and is bound to every instance.
// ----------------------------------------------------------------------------
module psc_checker
  import psc_pkg::*;
(
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_tvalid,
  input logic                  in_tready,
  input logic                  out_tvalid,
  input logic                  out_tready,
  input logic [OUT_DATA_W-1:0] out_tdata
);

  // A held result keeps its word until taken.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result word changed while stalled");

  // The clamp never lets steering reach the most negative code.
  a_steer_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[STEER_W-1:0] != 8'h80)
    else $error("steering outside the symmetric range");

  // No result appears in the cycle after reset.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

  // With the output register empty, an accepted word passes the input register and reaches the output.
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && !out_tvalid |=> ##1 out_tvalid)
    else $error("accepted word did not reach the output");

endmodule

bind pid_steering_controller psc_checker u_psc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

// ===== verif/tb_pid_steering_controller.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_pid_steering_controller: self-checking testbench for the PID controller
// Drives update and reset words through the input stream under several gain,
// clamp and deadband settings. A scoreboard predicts each result word and
// checks the result stream field by field, in order, with random stalls.
// ----------------------------------------------------------------------------
module tb_pid_steering_controller;
  import psc_pkg::*;

  // Register indexes that the block does not implement; writes are dropped.
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_6 = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_7 = 3'd7;

  localparam int SETTLE_CYCLES = 8;
  localparam int TIMEOUT_NS    = 4000000;

  // One result word, split into its fields.
  typedef struct packed {
    logic [D_W-1:0]     d_term;
    logic [I_W-1:0]     i_term;
    logic [P_W-1:0]     p_term;
    logic [STEER_W-1:0] steering;
  } steer_word_t;

  // Scoreboard: keeps its own copy of the registers and the integrator state,
  // predicts the result of every accepted word and checks results in order.
  class steer_scoreboard;
    logic signed [GAIN_W-1:0] p_gain;
    logic signed [GAIN_W-1:0] i_gain;
    logic signed [GAIN_W-1:0] d_gain;
    logic [ILIM_W-1:0]        wind_lim;
    logic [SLIM_W-1:0]        steer_max;
    logic [DBAND_W-1:0]       deadzone;
    longint                   err_sum;
    longint                   prev_err;
    steer_word_t              expected_q[$];
    int                       fail_count;

    function new();
      p_gain     = P_GAIN_RST;
      i_gain     = I_GAIN_RST;
      d_gain     = D_GAIN_RST;
      wind_lim   = WIND_LIM_RST;
      steer_max  = STEER_MAX_RST;
      deadzone   = DEADZONE_RST;
      err_sum    = 0;
      prev_err   = 0;
      fail_count = 0;
    endfunction

    // Mirror a register write; unknown indexes leave everything unchanged.
    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_P_GAIN:    p_gain    = data[GAIN_W-1:0];
        CFG_I_GAIN:    i_gain    = data[GAIN_W-1:0];
        CFG_D_GAIN:    d_gain    = data[GAIN_W-1:0];
        CFG_WIND_LIM:  wind_lim  = data[ILIM_W-1:0];
        CFG_STEER_MAX: steer_max = data[SLIM_W-1:0];
        CFG_DEADZONE:  deadzone  = data[DBAND_W-1:0];
        default: ;
      endcase
    endfunction

    // Predict the result of one accepted input word.
    function void note_word(logic req, logic [ERR_W-1:0] err_bits);
      longint      raw, e, mag, lim, sum_max, p, i, d, u;
      steer_word_t w;
      w = '0;
      if (req == REQ_RESET) begin
        err_sum  = 0;
        prev_err = 0;
      end else begin
        raw = longint'($signed(err_bits));
        // The most negative error cannot be negated in 11 bits; it saturates.
        e   = (raw == longint'(ERR_MIN)) ? longint'(ERR_MAX) : -raw;
        mag = (e < 0) ? -e : e;
        if (mag <= longint'(deadzone)) e = 0;

        // Anti wind-up clamp on the accumulated error.
        sum_max = (longint'(1) <<< (SUM_W - 1)) - 1;
        lim     = longint'(wind_lim);
        if (lim > sum_max) lim = sum_max;
        err_sum = err_sum + e;
        if (err_sum > lim) err_sum = lim;
        if (err_sum < -lim) err_sum = -lim;

        p        = longint'(p_gain) * e;
        i        = longint'(i_gain) * err_sum;
        d        = longint'(d_gain) * (e - prev_err);
        prev_err = e;

        // Round half toward plus infinity, then clamp the steering command.
        u = (p + i + d + (longint'(1) <<< (GAIN_FRAC - 1))) >>> GAIN_FRAC;
        if (u > longint'(steer_max)) u = longint'(steer_max);
        if (u < -longint'(steer_max)) u = -longint'(steer_max);

        w.steering = u[STEER_W-1:0];
        w.p_term   = p[P_W-1:0];
        w.i_term   = i[I_W-1:0];
        w.d_term   = d[D_W-1:0];
      end
      expected_q.push_back(w);
    endfunction

    function void compare(string name, logic signed [63:0] want, logic signed [63:0] got);
      if (want !== got) begin
        $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
        fail_count++;
      end
    endfunction

    // Check one accepted result word against the oldest prediction.
    function void check_word(logic [OUT_DATA_W-1:0] data);
      steer_word_t got, want;
      got = data[OUT_FLD_W-1:0];
      if (expected_q.size() == 0) begin
        $display("%0t: result word with nothing expected: expected none, actual %h",
                 $time, data);
        fail_count++;
        return;
      end
      want = expected_q.pop_front();
      compare("steering", $signed(want.steering), $signed(got.steering));
      compare("p_term", $signed(want.p_term), $signed(got.p_term));
      compare("i_term", $signed(want.i_term), $signed(got.i_term));
      compare("d_term", $signed(want.d_term), $signed(got.d_term));
      compare("padding", 64'sd0, $signed({1'b0, data[OUT_DATA_W-1:OUT_FLD_W]}));
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata;
  logic                  in_tuser;
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  steer_scoreboard sb;
  bit              gaps_on;

  pid_steering_controller dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  // 8 ns clock.
  initial clk = 1'b0;
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Result side: check every accepted word and stall at random.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready) sb.check_word(out_tdata);
      out_tready <= !(gaps_on && ($urandom_range(99) < 10));
    end
  end

  // Send one input word, with an occasional gap before it.
  task automatic send_word(input logic req, input logic [ERR_W-1:0] err);
    if (gaps_on && ($urandom_range(99) < 4)) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= req;
    in_tdata  <= {{(IN_DATA_W - ERR_W){1'b0}}, err};
    do @(posedge clk); while (!in_tready);
    sb.note_word(req, err);
  endtask

  // Stop sending and wait until every predicted result has come back.
  task automatic drain_results();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, data);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Load all six registers once the block is idle. Unused upper data bits
  // carry random values, and one write goes to an unimplemented index.
  task automatic load_settings(input int p, input int i, input int d,
                               input int il, input int sl, input int db);
    logic [CFG_DATA_W-1:0] data;
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    data = CFG_DATA_W'($urandom); data[GAIN_W-1:0] = p[GAIN_W-1:0];
    write_reg(CFG_P_GAIN, data);
    data = CFG_DATA_W'($urandom); data[GAIN_W-1:0] = i[GAIN_W-1:0];
    write_reg(CFG_I_GAIN, data);
    data = CFG_DATA_W'($urandom); data[GAIN_W-1:0] = d[GAIN_W-1:0];
    write_reg(CFG_D_GAIN, data);
    write_reg(CFG_WIND_LIM, il[ILIM_W-1:0]);
    data = CFG_DATA_W'($urandom); data[SLIM_W-1:0] = sl[SLIM_W-1:0];
    write_reg(CFG_STEER_MAX, data);
    data = CFG_DATA_W'($urandom); data[DBAND_W-1:0] = db[DBAND_W-1:0];
    write_reg(CFG_DEADZONE, data);
    write_reg($urandom_range(1) ? CFG_SPARE_7 : CFG_SPARE_6, CFG_DATA_W'($urandom));
  endtask

  // Random words: mostly updates, some near a random offset so that the
  // integrator winds up against its clamp, plus extremes and reset words.
  task automatic random_words(input int count, input int pause_at);
    int   k, mode, v, drift;
    logic req;
    drift = int'($urandom_range(1200)) - 600;
    for (k = 0; k < count; k++) begin
      if (k == pause_at) drain_results();
      req  = ($urandom_range(99) < 5) ? REQ_RESET : REQ_UPDATE;
      mode = $urandom_range(99);
      if (mode < 10) begin
        case ($urandom_range(2))
          0: v = ERR_MIN;
          1: v = ERR_MAX;
          default: v = 0;
        endcase
      end else if (mode < 45) begin
        v = int'($urandom_range(80)) - 40;
      end else if (mode < 70) begin
        v = drift + int'($urandom_range(20)) - 10;
      end else begin
        v = $urandom;
      end
      send_word(req, v[ERR_W-1:0]);
    end
  endtask

  // Main sequence.
  initial begin
    int k;
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tuser   = REQ_UPDATE;
    in_tdata   = '0;
    out_tready = 1'b0;
    cfg_valid  = 1'b0;
    cfg_index  = CFG_P_GAIN;
    cfg_data   = '0;
    gaps_on    = 1'b1;
    sb         = new();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset values: zero, extremes, negation of the most negative error.
    send_word(REQ_UPDATE, 11'sd0);
    send_word(REQ_UPDATE, ERR_MAX);
    send_word(REQ_UPDATE, ERR_MIN);
    send_word(REQ_UPDATE, -11'sd1);
    send_word(REQ_UPDATE, 11'sd1);
    send_word(REQ_UPDATE, ERR_MIN);
    send_word(REQ_RESET, ERR_MAX);
    send_word(REQ_UPDATE, 11'sd300);

    // Half-way sums round toward plus infinity.
    load_settings(128, 0, 0, int'(WIND_LIM_RST), 127, 0);
    send_word(REQ_UPDATE, 11'sd1);
    send_word(REQ_UPDATE, -11'sd1);
    send_word(REQ_UPDATE, 11'sd3);
    send_word(REQ_UPDATE, -11'sd3);

    // Deadband edge and the integrator clamp in both directions.
    load_settings(0, 256, 0, 10, 127, 5);
    send_word(REQ_UPDATE, 11'sd5);
    send_word(REQ_UPDATE, -11'sd5);
    send_word(REQ_UPDATE, 11'sd6);
    for (k = 0; k < 3; k++) send_word(REQ_UPDATE, -11'sd1023);
    for (k = 0; k < 2; k++) send_word(REQ_UPDATE, ERR_MAX);
    send_word(REQ_RESET, 11'sd0);

    // Random phases over a range of settings, reset values first, then extremes.
    load_settings(int'(P_GAIN_RST), int'(I_GAIN_RST), int'(D_GAIN_RST),
                  int'(WIND_LIM_RST), int'(STEER_MAX_RST), int'(DEADZONE_RST));
    random_words(80, -1);
    load_settings(32767, 32767, 32767, 8388607, 127, 0);
    random_words(80, -1);
    load_settings(-32768, -32768, -32768, 0, 127, 0);
    random_words(80, -1);
    load_settings(-32768, 32767, -32768, 8388607, 0, 1023);
    random_words(30, -1);

    // A long stretch with no idling on either side.
    gaps_on = 1'b0;
    load_settings($urandom, $urandom, $urandom, $urandom_range(5000),
                  $urandom_range(127), $urandom_range(60));
    random_words(80, -1);
    gaps_on = 1'b1;

    // The sender pauses half way until every result is back.
    load_settings($urandom, $urandom, $urandom, $urandom, $urandom_range(127),
                  $urandom_range(128));
    random_words(80, 40);

    for (k = 0; k < 3; k++) begin
      load_settings(int'($urandom_range(1023)) - 512, int'($urandom_range(255)) - 128,
                    int'($urandom_range(1023)) - 512, $urandom_range(20000),
                    $urandom_range(127), $urandom_range(30));
      random_words(70, -1);
    end

    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (sb.fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #(TIMEOUT_NS);
    $display("Regression FAIL");
    $finish;
  end

endmodule

// ===== files.f =====
sv/psc_pkg.sv
sv/pid_steering_controller.sv
sv/psc_checker.sv
verif/tb_pid_steering_controller.sv
